FILE: hw/rtl/hkse_pkg.sv
// shared types, constants and hash function for the hashed key set engine
`default_nettype none
package hkse_pkg;
  localparam int BUCKETS = 1024;
  localparam int WAYS = 4;
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_TOTAL = BUCKETS * WAYS;
  localparam int TOTAL_W = $clog2(SLOT_TOTAL + 1);
  localparam int COUNT_W = 13;
  localparam int KEY_W = 64;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic               success;
    logic               bucket_full;
    logic [COUNT_W-1:0] element_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_LOOKUP,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic hash;
    logic look;
  } cmd_t;

  // first half of the mix: up to the multiply by 21
  function automatic logic [63:0] mix_a(input logic [63:0] k);
    logic [63:0] h;
    h = (~k) + (k << 18);
    h = h ^ (h >> 31);
    return h;
  endfunction

  // second half of the mix after the multiply
  function automatic logic [31:0] mix_b(input logic [63:0] m);
    logic [63:0] h;
    h = m ^ (m >> 11);
    h = h + (h << 6);
    h = h ^ (h >> 22);
    return h[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/hkse_ctrl.sv
// controller state machine for the hashed key set engine
`default_nettype none
module hkse_ctrl import hkse_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic busy,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid && !busy) state_next = ST_HASH;
      ST_HASH:   state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_RESP;
      ST_RESP: begin
        if (out_ready) state_next = in_valid ? ST_HASH : ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !busy;
        cmd.load = in_valid & !busy;
      end
      ST_HASH:   cmd.hash = 1'b1;
      ST_LOOKUP: cmd.look = 1'b1;
      ST_RESP: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        cmd.load  = out_ready & in_valid;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/hkse_dp.sv
// datapath: hash, bucket memory, compare, write-back and count
`default_nettype none
module hkse_dp import hkse_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire req_t req,
  output logic      busy,
  output rsp_t      rsp
);
  logic [1:0]          mode_r;
  logic [KEY_W-1:0]    key_r;
  logic [63:0]         prod;
  logic [BUCKET_W-1:0] bucket;
  logic [KEY_W-1:0]    keys_mem [BUCKETS][WAYS];
  logic [WAYS-1:0]     valid_bits [BUCKETS];
  logic [KEY_W-1:0]    row_keys [WAYS];
  logic [WAYS-1:0]     row_valid;
  logic [WAYS-1:0]     valid_row_next;
  logic                valid_we;
  logic [BUCKET_W-1:0] clr_idx;
  logic [TOTAL_W-1:0]  total;
  logic [WAY_W-1:0]    hit_way, free_way;
  logic                hit, has_free;
  logic                success_r, full_r;
  logic [31:0]         hash;

  assign hash = mix_b(prod);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= req.mode;
      key_r  <= req.key;
      prod   <= mix_a(req.key) * 64'd21;
    end
    if (cmd.hash) bucket <= BUCKET_W'(hash % BUCKETS);
  end

  // registered row read
  always_ff @(posedge clk) begin
    if (cmd.hash) row_keys <= keys_mem[BUCKET_W'(hash % BUCKETS)];
  end

  always_ff @(posedge clk) begin
    if (cmd.hash) row_valid <= valid_bits[BUCKET_W'(hash % BUCKETS)];
  end

  always_comb begin
    hit = 1'b0;
    has_free = 1'b0;
    hit_way = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_valid[w] && row_keys[w] == key_r) begin
        hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!row_valid[w]) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look && mode_r == MODE_INSERT && !hit && has_free)
      keys_mem[bucket][free_way] <= key_r;
  end

  // updated valid row for the write-back
  always_comb begin
    valid_row_next = row_valid;
    valid_we = 1'b0;
    if (cmd.look) begin
      if (mode_r == MODE_INSERT && !hit && has_free) begin
        valid_row_next[free_way] = 1'b1;
        valid_we = 1'b1;
      end else if (mode_r == MODE_REMOVE && hit) begin
        valid_row_next[hit_way] = 1'b0;
        valid_we = 1'b1;
      end
    end
  end

  // clearing pass over every bucket row after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == BUCKET_W'(BUCKETS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) valid_bits[clr_idx] <= '0;
    else if (valid_we) valid_bits[bucket] <= valid_row_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.look) begin
      case (mode_r)
        MODE_INSERT: if (!hit && has_free) total <= total + 1'b1;
        MODE_REMOVE: if (hit && total != '0) total <= total - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      case (mode_r) inside
        MODE_INSERT: begin
          success_r <= !hit && has_free;
          full_r    <= !hit && !has_free;
        end
        MODE_SEARCH, MODE_REMOVE: begin
          success_r <= hit;
          full_r    <= 1'b0;
        end
        default: begin
          success_r <= 1'b0;
          full_r    <= 1'b0;
        end
      endcase
    end
  end

  // count shown after the update of the look cycle
  assign rsp = '{success: success_r, bucket_full: full_r,
                 element_count: COUNT_W'(total)};
endmodule
`default_nettype wire

FILE: hw/rtl/hashed_key_set_engine.sv
// top level of the hashed key set engine
// usage:
// - req channel (req_valid/req_ready, req_t) carries one operation: insert,
//   search or remove of a 64-bit key; rsp channel (rsp_valid/rsp_ready, rsp_t)
//   returns success, bucket_full and the key count after the operation
// - the result is valid once the controller has passed its hash and lookup
//   states: the multiply of the mix happens at acceptance, then the hash state
//   finishes the mix and reads the bucket row, the lookup state does the
//   compare and write-back; the result then waits in its register
// - a new request is accepted in the cycle its predecessor's result is taken,
//   so sustained throughput is set by the accept/result, hash-and-read and
//   compare-and-write controller states; no request is taken mid-operation
// - the bucket row is WAYS slots wide, read whole and compared in parallel;
//   insert takes the lowest free slot, remove clears the matching slot
// - reset clears the key count and starts a clearing pass that zeroes the
//   valid bits one bucket row per cycle over all BUCKETS (1024) rows; req_ready
//   stays low until it is done; slot keys are never read without a valid bit
// - when rsp_ready is low the result holds and no new request is accepted
// - operation code 3 changes nothing and reports failure
`default_nettype none
module hashed_key_set_engine import hkse_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);
  cmd_t cmd;
  logic dp_busy;

  hkse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .busy      (dp_busy),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .out_valid (rsp_valid),
    .out_ready (rsp_ready),
    .cmd       (cmd)
  );

  hkse_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .busy (dp_busy),
    .rsp  (rsp)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/hkse_checker.sv
// port-level checks for the hashed key set engine
`default_nettype none
module hkse_checker import hkse_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);
  // full flag never comes with success
  a_full_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.success && rsp.bucket_full)) else $error("full with success");

  // a result is held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("result dropped");

  // an accepted request leads to a result once the hash and lookup states pass
  a_lat: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##3 rsp_valid) else $error("no result");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !rsp_valid) else $error("result after reset");
endmodule

bind hashed_key_set_engine hkse_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire

FILE: tb/tb_hashed_key_set_engine.sv
// testbench for the hashed key set engine: directed and random set operations
`default_nettype none
module tb_hashed_key_set_engine;
  import hkse_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  hashed_key_set_engine dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the table
  logic [63:0] shadow_keys [SLOT_TOTAL];
  logic        shadow_valid [SLOT_TOTAL];
  int unsigned shadow_total;
  rsp_t        pending_rsp [$];
  int          errors = 0;

  // idling control: percent of cycles each side idles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_on = 1'b0;
  event        hold_start;

  // keys sent for insert, reused so searches and removes can hit
  logic [63:0] known_keys [$];

  function automatic int unsigned hash_bucket(logic [63:0] k);
    logic [63:0] h;
    h = (~k) + (k << 18);
    h = h ^ (h >> 31);
    h = h * 64'd21;
    h = h ^ (h >> 11);
    h = h + (h << 6);
    h = h ^ (h >> 22);
    return h[31:0] % BUCKETS;
  endfunction

  function automatic rsp_t predict_op(logic [1:0] mode, logic [63:0] key);
    int unsigned base;
    int hit;
    int free_slot;
    rsp_t r;
    base = hash_bucket(key) * WAYS;
    hit = -1;
    free_slot = -1;
    r = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[base + w]) begin
        if (hit < 0 && shadow_keys[base + w] == key) hit = w;
      end else if (free_slot < 0) begin
        free_slot = w;
      end
    end
    case (mode)
      MODE_INSERT: begin
        if (hit < 0) begin
          if (free_slot >= 0) begin
            shadow_keys[base + free_slot] = key;
            shadow_valid[base + free_slot] = 1'b1;
            shadow_total++;
            r.success = 1'b1;
          end else begin
            r.bucket_full = 1'b1;
          end
        end
      end
      MODE_SEARCH: r.success = (hit >= 0);
      MODE_REMOVE: begin
        if (hit >= 0) begin
          shadow_valid[base + hit] = 1'b0;
          if (shadow_total > 0) shadow_total--;
          r.success = 1'b1;
        end
      end
      default: ;
    endcase
    r.element_count = shadow_total[COUNT_W-1:0];
    return r;
  endfunction

  // one transaction on the request channel; valid drops only when idling
  task automatic send_op(logic [1:0] mode, logic [63:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{mode: mode, key: key};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_rsp.push_back(predict_op(mode, key));
    if (mode == MODE_INSERT) known_keys.push_back(key);
  endtask

  // long receiver hold-off, counted here
  always begin
    @(hold_start);
    hold_on <= 1'b1;
    repeat (60) @(posedge clk);
    hold_on <= 1'b0;
  end

  // receiver ready, with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (hold_on) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, rsp);
        errors++;
      end else begin
        rsp_t want;
        want = pending_rsp.pop_front();
        if (rsp.success !== want.success)
          $display("%0t: success expected %b actual %b", $realtime, want.success, rsp.success);
        if (rsp.bucket_full !== want.bucket_full)
          $display("%0t: bucket_full expected %b actual %b", $realtime,
                   want.bucket_full, rsp.bucket_full);
        if (rsp.element_count !== want.element_count)
          $display("%0t: element_count expected %0d actual %0d", $realtime,
                   want.element_count, rsp.element_count);
        if (rsp !== want) errors++;
      end
    end
  end

  task automatic drain;
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key;
    return {$urandom, $urandom};
  endfunction

  // key that lands in a chosen bucket, found by search
  function automatic logic [63:0] key_in_bucket(int unsigned b);
    logic [63:0] k;
    do k = rand_key(); while (hash_bucket(k) != b);
    return k;
  endfunction

  task automatic test_directed;
    logic [63:0] row_keys [5];
    send_op(MODE_SEARCH, 64'd0);
    send_op(MODE_REMOVE, 64'd0);
    send_op(MODE_INSERT, 64'd0);
    send_op(MODE_INSERT, 64'd0);                  // duplicate
    send_op(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(MODE_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF);  // unused mode
    send_op(MODE_NONE, 64'd0);
    // fill one bucket, overflow it, then free the lowest slot and refill
    for (int i = 0; i < 5; i++) row_keys[i] = key_in_bucket(7);
    for (int i = 0; i < 5; i++) send_op(MODE_INSERT, row_keys[i]);
    send_op(MODE_REMOVE, row_keys[0]);
    send_op(MODE_INSERT, row_keys[4]);
    send_op(MODE_SEARCH, row_keys[4]);
    send_op(MODE_REMOVE, row_keys[2]);
    send_op(MODE_REMOVE, row_keys[2]);
    send_op(MODE_SEARCH, row_keys[3]);
    send_op(MODE_REMOVE, 64'd0);
    send_op(MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
  endtask

  task automatic random_op;
    logic [1:0] mode;
    logic [63:0] key;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) mode = MODE_INSERT;
    else if (pick < 70) mode = MODE_SEARCH;
    else if (pick < 95) mode = MODE_REMOVE;
    else mode = MODE_NONE;
    // mostly known keys or crowded buckets, so hits and full rows occur
    pick = $urandom_range(99);
    if (pick < 40 && known_keys.size() > 0)
      key = known_keys[$urandom_range(known_keys.size() - 1)];
    else if (pick < 60)
      key = key_in_bucket($urandom_range(15));
    else
      key = rand_key();
    send_op(mode, key);
  endtask

  task automatic test_random_phase(int unsigned n, int unsigned s_pct, int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < n; i++) random_op();
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    -> hold_start;
    for (int i = 0; i < 30; i++) random_op();
    drain();
  endtask

  initial begin
    for (int i = 0; i < SLOT_TOTAL; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_keys[i] = '0;
    end
    shadow_total = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(500, 0, 0);
    test_random_phase(450, 69, 0);
    test_random_phase(450, 0, 69);
    test_random_phase(450, 22, 22);
    test_backpressure();
    test_random_phase(80, 0, 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("hashed_key_set_engine test passed");
    end else begin
      $display("hashed_key_set_engine test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("hashed_key_set_engine test failed");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/hkse_pkg.sv
hw/rtl/hkse_ctrl.sv
hw/rtl/hkse_dp.sv
hw/rtl/hashed_key_set_engine.sv
hw/rtl/hkse_checker.sv
tb/tb_hashed_key_set_engine.sv
